// File: sv/pip_pkg.sv
// ---------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Coordinate widths, request and job formats, and the edge test result.
// ---------------------------------------------------------------------------
package pip_pkg;

   localparam int COORD_BITS  = 31;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // vertex counter saturates at three: a polygon needs three corners
   localparam logic [1:0] VCOUNT_MAX   = 2'd3;
   localparam logic [1:0] VCOUNT_CLOSE = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   // per-request control carried alongside the edge tests
   typedef struct packed {
      logic start;  // opens a new polygon, no regular edge
      logic last;   // closes the polygon, always yields a result
      logic emit;   // polygon has three or more vertices, test closing edge
   } ctl_type;

   // one classified request: regular edge prev->vertex, closing edge vertex->first
   typedef struct packed {
      ctl_type   ctl;
      coord_type px;
      coord_type py;
      coord_type ax;
      coord_type ay;
      coord_type vx;
      coord_type vy;
      coord_type fx;
      coord_type fy;
   } job_type;

   typedef struct packed {
      logic bnd;  // point on the edge
      logic tog;  // edge crosses the ray, flip parity
   } edge_res_type;

   function automatic diff_type coord_sub(coord_type a, coord_type b);
      coord_sub = diff_type'(a) - diff_type'(b);
   endfunction

endpackage

// File: sv/point_in_polygon_test.sv
// Throughput: one vertex request per cycle while the queue has room; the edge-test
// pipeline (differences, products, compares) and the accumulator each take one per
// cycle while not stalled. A waiting result stalls the back end only when another
// result is behind it.
// Reset (synchronous, active high) clears the vertex count, queue, pipeline valids,
// crossing parity, boundary flag and result valid; the next request opens a polygon.
// ---------------------------------------------------------------------------
// point_in_polygon_test: even-odd point-in-polygon test
// Streams polygon vertices with the query point; on the last vertex returns
// inside (or on boundary) and on-boundary flags.
// ---------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  coord_type req_point_x,
   input  coord_type req_point_y,
   input  coord_type req_vertex_x,
   input  coord_type req_vertex_y,
   input  logic      req_first_vertex,
   input  logic      req_last_vertex,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_inside_res,
   output logic      rsp_on_boundary
);

   // front end -> queue
   logic    fq_valid;
   job_type fq_job;
   // queue -> back end
   logic    qb_valid, qb_ready;
   job_type qb_job;

   // Front end: classify each request (start, close) and attach the
   // previous and first vertex so every edge test is self-contained.
   pip_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .q_ready          (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .q_valid          (fq_valid),
      .q_job            (fq_job)
   );

   // Queue: absorb requests while the back end holds a pending result.
   pip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (req_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   // Back end: regular and closing edge tests in parallel, then accumulate
   // parity and boundary hit; drop requests that produce no result.
   pip_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (qb_valid),
      .in_ready        (qb_ready),
      .in_job          (qb_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_on_boundary (rsp_on_boundary)
   );

endmodule

// File: sv/pip_front.sv
// ---------------------------------------------------------------------------
// pip_front: request front end
// Tracks the first and previous vertex and the vertex count, and turns
// each request into a job for the edge-test back end.
// ---------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      q_ready,
   input  coord_type req_point_x,
   input  coord_type req_point_y,
   input  coord_type req_vertex_x,
   input  coord_type req_vertex_y,
   input  logic      req_first_vertex,
   input  logic      req_last_vertex,
   output logic      q_valid,
   output job_type   q_job
);

   coord_type  first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic [1:0] count_ff, count_in;
   logic       accept, start;

   assign accept  = req_valid && q_ready;
   assign q_valid = req_valid;
   assign start   = req_first_vertex || (count_ff == 2'd0);

   always_comb begin
      if (req_last_vertex) begin
         count_in = 2'd0;
      end else if (start) begin
         count_in = 2'd1;
      end else if (count_ff == VCOUNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 2'd1;
      end
   end

   always_comb begin
      q_job.ctl.start = start;
      q_job.ctl.last  = req_last_vertex;
      q_job.ctl.emit  = req_last_vertex && !start && (count_ff >= VCOUNT_CLOSE);
      q_job.px        = req_point_x;
      q_job.py        = req_point_y;
      q_job.ax        = prev_x_ff;
      q_job.ay        = prev_y_ff;
      q_job.vx        = req_vertex_x;
      q_job.vy        = req_vertex_y;
      q_job.fx        = first_x_ff;
      q_job.fy        = first_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // vertex registers: payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= req_vertex_x;
         prev_y_ff <= req_vertex_y;
         if (start) begin
            first_x_ff <= req_vertex_x;
            first_y_ff <= req_vertex_y;
         end
      end
   end

endmodule

// File: sv/pip_queue.sv
// ---------------------------------------------------------------------------
// pip_queue: job queue
// Short FIFO between front end and back end so each side stalls alone.
// ---------------------------------------------------------------------------
module pip_queue import pip_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type              qmem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = qmem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   function automatic logic [QPTR_BITS-1:0] ptr_next(logic [QPTR_BITS-1:0] p);
      if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + QPTR_BITS'(1);
      end
   endfunction

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qmem_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// File: sv/pip_edge.sv
// ---------------------------------------------------------------------------
// pip_edge: three-stage edge test
// Differences, cross products, then exact compares for one edge a->b.
// ---------------------------------------------------------------------------
module pip_edge import pip_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  coord_type    ax,
   input  coord_type    ay,
   input  coord_type    bx,
   input  coord_type    by,
   input  coord_type    px,
   input  coord_type    py,
   output edge_res_type res
);

   diff_type     dbx_ff, pya_ff, bya_ff, pxa_ff, pxb_ff, dab_ff, axb_ff, pyb_ff;
   logic         rng1_ff, strad1_ff;
   prod_type     l_ff, r_ff, lhs_ff, rhs_ff;
   logic         rng2_ff, strad2_ff, dpos2_ff;
   edge_res_type res_ff, res_in;
   logic         x_rng, y_rng, left;

   assign x_rng = ((px >= ax) && (px <= bx)) || ((px >= bx) && (px <= ax));
   assign y_rng = ((py >= ay) && (py <= by)) || ((py >= by) && (py <= ay));

   always_comb begin
      left       = dpos2_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff);
      res_in.bnd = (l_ff == r_ff) && rng2_ff;
      res_in.tog = !res_in.bnd && strad2_ff && left;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: coordinate differences and range checks
         dbx_ff    <= coord_sub(bx, ax);
         pya_ff    <= coord_sub(py, ay);
         bya_ff    <= coord_sub(by, ay);
         pxa_ff    <= coord_sub(px, ax);
         pxb_ff    <= coord_sub(px, bx);
         dab_ff    <= coord_sub(ay, by);
         axb_ff    <= coord_sub(ax, bx);
         pyb_ff    <= coord_sub(py, by);
         rng1_ff   <= x_rng && y_rng;
         strad1_ff <= (by > py) != (ay > py);
         // stage 2: cross products
         l_ff      <= prod_type'(dbx_ff) * prod_type'(pya_ff);
         r_ff      <= prod_type'(bya_ff) * prod_type'(pxa_ff);
         lhs_ff    <= prod_type'(pxb_ff) * prod_type'(dab_ff);
         rhs_ff    <= prod_type'(axb_ff) * prod_type'(pyb_ff);
         rng2_ff   <= rng1_ff;
         strad2_ff <= strad1_ff;
         dpos2_ff  <= !dab_ff[DIFF_BITS-1] && (dab_ff != '0);
         // stage 3: boundary and crossing decision
         res_ff    <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: sv/pip_back.sv
// ---------------------------------------------------------------------------
// pip_back: edge-test back end
// Runs the regular and closing edge tests, accumulates parity and the
// boundary flag, and holds the result in an output register.
// ---------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output logic    rsp_inside_res,
   output logic    rsp_on_boundary
);

   logic         v1_ff, v2_ff, v3_ff;
   ctl_type      ctl1_ff, ctl2_ff, ctl3_ff;
   logic         par_ff, par_in, hit_ff, hit_in;
   logic         rsp_valid_ff, inside_ff, onb_ff;
   logic         stall, en, acc;
   edge_res_type reg_res, cls_res;

   // hold the pipe only when a result is ready to leave but cannot
   assign stall    = rsp_valid_ff && !rsp_ready && v3_ff && ctl3_ff.last;
   assign en       = !stall;
   assign in_ready = en;
   assign acc      = en && v3_ff;

   pip_edge u_reg_edge (
      .clock (clock),
      .en    (en),
      .ax    (in_job.ax),
      .ay    (in_job.ay),
      .bx    (in_job.vx),
      .by    (in_job.vy),
      .px    (in_job.px),
      .py    (in_job.py),
      .res   (reg_res)
   );

   pip_edge u_close_edge (
      .clock (clock),
      .en    (en),
      .ax    (in_job.vx),
      .ay    (in_job.vy),
      .bx    (in_job.fx),
      .by    (in_job.fy),
      .px    (in_job.px),
      .py    (in_job.py),
      .res   (cls_res)
   );

   always_comb begin
      par_in = ctl3_ff.start ? 1'b0 : par_ff;
      hit_in = ctl3_ff.start ? 1'b0 : hit_ff;
      if (!ctl3_ff.start) begin
         par_in = par_in ^ reg_res.tog;
         hit_in = hit_in | reg_res.bnd;
      end
      if (ctl3_ff.emit) begin
         par_in = par_in ^ cls_res.tog;
         hit_in = hit_in | cls_res.bnd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         par_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            v1_ff <= in_valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         if (acc) begin
            par_ff <= ctl3_ff.last ? 1'b0 : par_in;
            hit_ff <= ctl3_ff.last ? 1'b0 : hit_in;
         end
         if (acc && ctl3_ff.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl1_ff <= in_job.ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
      if (acc && ctl3_ff.last) begin
         inside_ff <= ctl3_ff.emit && (hit_in || par_in);
         onb_ff    <= ctl3_ff.emit && hit_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inside_res  = inside_ff;
   assign rsp_on_boundary = onb_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v3_ff && ctl3_ff.last))
      else $error("result raised without a closing vertex");

   a_onb_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!onb_ff || inside_ff))
      else $error("boundary hit reported outside");

   a_stall_no_take: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(v3_ff) && $stable(ctl3_ff))
      else $error("pipeline moved during stall");

endmodule
